FILE: src/adr_pkg.sv
// Package: constants, types and the arctangent table of the dead reckoning integrator.
`default_nettype none
package adr_pkg;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int POS_WIDTH_DEF = 40;
	localparam int ATAN_ENTRIES = 24;
	localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
	localparam int VW = 34;

	typedef enum logic [2:0] {
		ST_IDLE, ST_SQR, ST_CORDIC, ST_MUL, ST_ACC, ST_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic busy;
	} ctl_t;

	function automatic logic [31:0] atan_turn(input logic [4:0] i);
		logic [31:0] v;
		begin
			case (i)
				5'd0: v = 32'h20000000;
				5'd1: v = 32'h12E4051E;
				5'd2: v = 32'h09FB385B;
				5'd3: v = 32'h051111D4;
				5'd4: v = 32'h028B0D43;
				5'd5: v = 32'h0145D7E1;
				5'd6: v = 32'h00A2F61E;
				5'd7: v = 32'h00517C55;
				5'd8: v = 32'h0028BE53;
				5'd9: v = 32'h00145F2F;
				5'd10: v = 32'h000A2F98;
				5'd11: v = 32'h000517CC;
				5'd12: v = 32'h00028BE6;
				5'd13: v = 32'h000145F3;
				5'd14: v = 32'h0000A2FA;
				5'd15: v = 32'h0000517D;
				5'd16: v = 32'h000028BE;
				5'd17: v = 32'h0000145F;
				5'd18: v = 32'h00000A30;
				5'd19: v = 32'h00000518;
				5'd20: v = 32'h0000028C;
				5'd21: v = 32'h00000146;
				5'd22: v = 32'h000000A3;
				5'd23: v = 32'h00000051;
				default: v = 32'h0;
			endcase
			return v;
		end
	endfunction
endpackage
`default_nettype wire

FILE: src/adr_cordic.sv
// Module: iterative CORDIC giving sine and cosine of a 16-bit heading.
`default_nettype none
module adr_cordic #(
	parameter int CORDIC_STEPS = adr_pkg::CORDIC_STEPS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire adr_pkg::ctl_t                 ctl,
	input  wire logic [15:0]                   angle,
	output logic                               done,
	output logic signed [adr_pkg::VW-1:0]      sin_v,
	output logic signed [adr_pkg::VW-1:0]      cos_v
);
	import adr_pkg::*;
	localparam int NSTEP = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;

	logic signed [VW-1:0] x_q, y_q;
	logic signed [33:0] z_q;
	logic [1:0] quad_q;
	logic [4:0] i_q;
	logic run_q;
	logic [15:0] qa, res;
	logic signed [VW-1:0] dx, dy, at;

	always_comb begin
		qa = angle + 16'h2000;
		res = angle - {qa[15:14], 14'd0};
		dx = y_q >>> i_q;
		dy = x_q >>> i_q;
		at = VW'(atan_turn(i_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			i_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (ctl.start) begin
				run_q <= 1'b1;
				i_q <= '0;
				quad_q <= qa[15:14];
				z_q <= {{2{res[15]}}, res, 16'd0};
				x_q <= VW'(CORDIC_GAIN);
				y_q <= '0;
			end else if (run_q) begin
				// one rotation step per cycle
				if (!z_q[33]) begin
					x_q <= x_q - dx; y_q <= y_q + dy; z_q <= z_q - at;
				end else begin
					x_q <= x_q + dx; y_q <= y_q - dy; z_q <= z_q + at;
				end
				if (i_q == 5'(NSTEP - 1)) begin
					run_q <= 1'b0;
					done <= 1'b1;
				end
				i_q <= i_q + 5'd1;
			end
		end
	end

	always_comb begin
		case (quad_q)
			2'd0: begin cos_v = x_q; sin_v = y_q; end
			2'd1: begin cos_v = -y_q; sin_v = x_q; end
			2'd2: begin cos_v = -x_q; sin_v = -y_q; end
			default: begin cos_v = y_q; sin_v = -x_q; end
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n) done |-> !run_q)
		else $error("done while rotating");
	assert property (@(posedge clk) disable iff (!arst_n) ctl.start |=> run_q)
		else $error("start not taken");
	assert property (@(posedge clk) disable iff (!arst_n) run_q |-> ctl.busy)
		else $error("rotation outside busy");
endmodule
`default_nettype wire

FILE: src/adr_serial_mul.sv
// Module: bit-serial signed multiplier, one multiplier bit per cycle.
`default_nettype none
module adr_serial_mul #(
	parameter int AW = 34,
	parameter int BW = 17
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic signed [AW-1:0]   a,
	input  wire logic signed [BW-1:0]   b,
	output logic                        done,
	output logic signed [AW+BW-1:0]     p
);
	localparam int CW = $clog2(BW + 1);
	logic signed [AW+BW-1:0] a_q;
	logic [BW-1:0] b_q;
	logic [CW-1:0] n_q;
	logic run_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done <= 1'b0;
			n_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				n_q <= '0;
				a_q <= (AW+BW)'(a);
				b_q <= b;
				p <= '0;
			end else if (run_q) begin
				// top bit of b carries negative weight
				if (b_q[0]) begin
					if (n_q == CW'(BW - 1)) p <= p - a_q;
					else p <= p + a_q;
				end
				a_q <= a_q <<< 1;
				b_q <= b_q >> 1;
				n_q <= n_q + 1'b1;
				if (n_q == CW'(BW - 1)) begin
					run_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

FILE: src/arcade_dead_reckoning_integrator.sv
// Top level: joystick dead reckoning integrator.
//  channel | direction | handshake              | payload
//  in      | input     | in_valid / in_ready    | stick_x, stick_y
//  cfg     | input     | cfg_valid / cfg_ready  | cfg_data (square_inputs)
//  out     | output    | out_valid / out_ready  | speed, heading, pos_x, pos_y
// One transaction at a time: squaring on a serial multiplier (skipped when off),
// then the CORDIC loop, then the two bit-serial multiplies side by side, then
// the accumulate step, which updates the saturating position registers.
// Asynchronous reset clears the control, squaring, heading, speed and position
// registers. A finished result holds in the output register until taken; a new
// sample is accepted in the cycle the result leaves.
`default_nettype none
module arcade_dead_reckoning_integrator #(
	parameter int CORDIC_STEPS = adr_pkg::CORDIC_STEPS_DEF,
	parameter int POS_WIDTH = adr_pkg::POS_WIDTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic signed [15:0]          stick_x,
	input  wire logic signed [15:0]          stick_y,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic                        cfg_data,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic signed [16:0]               speed,
	output logic [15:0]                      heading,
	output logic signed [POS_WIDTH-1:0]      pos_x,
	output logic signed [POS_WIDTH-1:0]      pos_y
);
	import adr_pkg::*;
	localparam int PW = VW + 17;
	localparam int AW = (POS_WIDTH > PW - 30 ? POS_WIDTH : PW - 30) + 2;

	state_t state_q, state_d;
	logic sq_q;
	logic signed [16:0] speed_q;
	logic [15:0] head_q;
	logic signed [POS_WIDTH-1:0] xa_q, ya_q;
	ctl_t cctl;
	logic c_done, mx_done, my_done, ms_done;
	logic signed [VW-1:0] sn, cs;
	logic signed [PW-1:0] px, py, ps;
	logic signed [AW-1:0] dx, dy, sx, sy, mx, mn;
	logic signed [POS_WIDTH-1:0] nx, ny;
	logic acc_en, ld_in, mul_go;

	assign cfg_ready = 1'b1;
	assign in_ready = (state_q == ST_IDLE) || (state_q == ST_OUT && out_ready);
	assign out_valid = (state_q == ST_OUT);
	assign ld_in = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		acc_en = 1'b0;
		mul_go = 1'b0;
		cctl.start = 1'b0;
		cctl.busy = (state_q != ST_IDLE) && (state_q != ST_OUT);
		case (state_q)
			ST_IDLE, ST_OUT: begin
				if (state_q == ST_OUT && out_ready) state_d = ST_IDLE;
				if (ld_in) state_d = ST_SQR;
			end
			ST_SQR: if (ms_done || !sq_q) begin
				cctl.start = 1'b1;
				state_d = ST_CORDIC;
			end
			ST_CORDIC: if (c_done) begin
				mul_go = 1'b1;
				state_d = ST_MUL;
			end
			ST_MUL: if (mx_done) state_d = ST_ACC;
			ST_ACC: begin
				acc_en = 1'b1;
				state_d = ST_OUT;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// squaring uses its own serial multiplier on the raw stick_y value
	adr_serial_mul #(.AW(VW), .BW(17)) u_msq (
		.clk(clk), .arst_n(arst_n), .start(ld_in),
		.a(VW'(stick_y)), .b(17'(stick_y)), .done(ms_done), .p(ps));

	adr_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .ctl(cctl), .angle(head_q),
		.done(c_done), .sin_v(sn), .cos_v(cs));

	adr_serial_mul #(.AW(VW), .BW(17)) u_mx (
		.clk(clk), .arst_n(arst_n), .start(mul_go), .a(sn), .b(speed_q),
		.done(mx_done), .p(px));
	adr_serial_mul #(.AW(VW), .BW(17)) u_my (
		.clk(clk), .arst_n(arst_n), .start(mul_go), .a(cs), .b(speed_q),
		.done(my_done), .p(py));

	always_comb begin
		mx = AW'((64'sd1 <<< (POS_WIDTH - 1)) - 64'sd1);
		mn = -mx - AW'(1);
		dx = AW'((px + PW'(64'sd1 <<< 29)) >>> 30);
		dy = AW'((py + PW'(64'sd1 <<< 29)) >>> 30);
		sx = AW'(xa_q) + dx;
		sy = AW'(ya_q) + dy;
		nx = (sx > mx) ? POS_WIDTH'(mx) : (sx < mn) ? POS_WIDTH'(mn) : POS_WIDTH'(sx);
		ny = (sy > mx) ? POS_WIDTH'(mx) : (sy < mn) ? POS_WIDTH'(mn) : POS_WIDTH'(sy);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_q <= 1'b0;
			head_q <= '0;
			speed_q <= '0;
			xa_q <= '0;
			ya_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) sq_q <= cfg_data;
			if (ld_in) begin
				head_q <= head_q + {stick_x[14:0], 1'b0};
				speed_q <= 17'(stick_y);
			end
			if (state_q == ST_SQR && sq_q && ms_done) speed_q <= 17'(ps >>> 15);
			if (acc_en) begin
				xa_q <= nx;
				ya_q <= ny;
			end
		end
	end

	assign speed = speed_q;
	assign heading = head_q;
	assign pos_x = xa_q;
	assign pos_y = ya_q;

	assert property (@(posedge clk) disable iff (!arst_n) mx_done |-> my_done)
		else $error("multipliers out of step");
	assert property (@(posedge clk) disable iff (!arst_n) out_valid && !out_ready |=> $stable(pos_x))
		else $error("result moved while held");
	assert property (@(posedge clk) disable iff (!arst_n) acc_en |=> out_valid)
		else $error("result not presented");
endmodule
`default_nettype wire

FILE: dv/arcade_dead_reckoning_integrator_tb.sv
// Testbench: joystick dead reckoning integrator checked against a bit-exact predictor.
module arcade_dead_reckoning_integrator_tb;
	localparam int PW = adr_pkg::POS_WIDTH_DEF;
	localparam int STEPS = adr_pkg::CORDIC_STEPS_DEF;
	localparam int WATCHDOG = 4000;

	typedef struct {
		logic signed [16:0]   spd;
		logic [15:0]          hdg;
		logic signed [PW-1:0] px;
		logic signed [PW-1:0] py;
	} motion_t;

	// Tracks the integrator state and holds the predicted motion results.
	class motion_scoreboard;
		bit               squaring;
		logic [15:0]      hdg_acc;
		longint           xa, ya;
		motion_t          pending[$];
		int               mismatches;

		function void clear();
			squaring = 0; hdg_acc = 0; xa = 0; ya = 0;
		endfunction

		function longint sat(longint a, longint d);
			longint mx, mn;
			mx = (longint'(1) <<< (PW - 1)) - 1;
			mn = -mx - 1;
			if (d > 0 && a > mx - d) return mx;
			if (d < 0 && a < mn - d) return mn;
			return a + d;
		endfunction

		// Rotate by the residual within the nearest quadrant, then turn exactly.
		function void sin_cos(logic [15:0] h, output longint sn, output longint cs);
			logic [1:0]         q;
			logic [15:0]        res;
			longint             z, x, y, dx, dy;
			q = 2'((h + 16'h2000) >> 14);
			res = h - {q, 14'd0};
			z = longint'($signed(res)) * 65536;
			x = adr_pkg::CORDIC_GAIN;
			y = 0;
			for (int i = 0; i < STEPS && i < adr_pkg::ATAN_ENTRIES; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx; y += dy; z -= longint'(adr_pkg::atan_turn(5'(i)));
				end else begin
					x += dx; y -= dy; z += longint'(adr_pkg::atan_turn(5'(i)));
				end
			end
			case (q)
				2'd0: begin cs = x; sn = y; end
				2'd1: begin cs = -y; sn = x; end
				2'd2: begin cs = -x; sn = -y; end
				default: begin cs = y; sn = -x; end
			endcase
		endfunction

		function void note_sample(logic signed [15:0] sx, logic signed [15:0] sy);
			longint  spd, sn, cs;
			motion_t m;
			spd = squaring ? ((longint'(sy) * sy) >>> 15) : longint'(sy);
			hdg_acc = hdg_acc + 16'(2 * longint'(sx));
			sin_cos(hdg_acc, sn, cs);
			xa = sat(xa, (spd * sn + (longint'(1) <<< 29)) >>> 30);
			ya = sat(ya, (spd * cs + (longint'(1) <<< 29)) >>> 30);
			m.spd = 17'(spd); m.hdg = hdg_acc; m.px = PW'(xa); m.py = PW'(ya);
			pending.push_back(m);
		endfunction

		function void check_result(motion_t got);
			motion_t e;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result: spd %0d", got.spd);
				return;
			end
			e = pending.pop_front();
			if (got.spd !== e.spd || got.hdg !== e.hdg || got.px !== e.px || got.py !== e.py)
			begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: exp spd %0d hdg %0d x %0d y %0d, got %0d %0d %0d %0d",
						e.spd, e.hdg, e.px, e.py, got.spd, got.hdg, got.px, got.py);
			end
		endfunction
	endclass

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, in_ready, cfg_valid = 0, cfg_ready, cfg_data = 0;
	logic out_valid, out_ready = 0;
	logic signed [15:0] stick_x = 0, stick_y = 0;
	logic signed [16:0] speed;
	logic [15:0] heading;
	logic signed [PW-1:0] pos_x, pos_y;
	motion_scoreboard sb = new();
	int idle_cycles = 0;
	bit out_stall_free = 0;

	always #5 clk = ~clk;

	arcade_dead_reckoning_integrator u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .stick_x(stick_x), .stick_y(stick_y),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.out_valid(out_valid), .out_ready(out_ready),
		.speed(speed), .heading(heading), .pos_x(pos_x), .pos_y(pos_y)
	);

	// Sample on the rising edge: score results, note samples, run the watchdog.
	always @(posedge clk) begin
		motion_t got;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got.spd = speed; got.hdg = heading; got.px = pos_x; got.py = pos_y;
				sb.check_result(got);
			end
			if (in_valid && in_ready) sb.note_sample(stick_x, stick_y);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG) begin
				$display("arcade_dead_reckoning_integrator_tb: done, errors");
				$finish;
			end
		end
	end

	// Receiver: random stalls between results, none at all in some stretches.
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			gap = out_stall_free ? 0 : $urandom_range(0, 12);
			if (gap > 0) begin
				out_ready <= 0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	// Offer one sample and hold it until accepted; valid stays up for the next
	// sample when there is no gap, so drop it with stop_input before any wait.
	task automatic send_sample(logic signed [15:0] sx, logic signed [15:0] sy, int gap);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1; stick_x <= sx; stick_y <= sy;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// Drop the input valid; called on a falling edge.
	task automatic stop_input();
		in_valid <= 0;
	endtask

	// Drain every pending result, then write the squaring register.
	task automatic write_squaring(bit v);
		stop_input();
		wait (sb.pending.size() == 0);
		@(negedge clk);
		cfg_valid <= 1; cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.squaring = v;
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	function automatic logic signed [15:0] pick_stick();
		case ($urandom_range(0, 5))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return 16'(int'($urandom_range(0, 64)) - 32);
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		logic signed [15:0] corners[6] = '{16'sh8000, 16'sh7FFF, 0, 1, -1, 16'sh2000};
		sb.clear();
		repeat (6) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// Directed: field extremes in both speed modes, quadrant edges, heading wrap.
		for (int m = 0; m < 2; m++) begin
			write_squaring(m[0]);
			foreach (corners[i])
				send_sample(corners[i], corners[(i + 2) % 6], $urandom_range(0, 3));
		end
		for (int k = 0; k < 6; k++) send_sample(16'sh1000 + 16'(k), 16'sh7FFF, 0);

		// Drive full speed at a constant heading with the receiver never stalling.
		write_squaring(0);
		send_sample(16'sh8000, 16'sh7FFF, 0);
		out_stall_free = 1;
		for (int k = 0; k < 40; k++) send_sample(0, 16'sh7FFF, 0);
		out_stall_free = 0;

		// Random phases across both speed modes; a full drain between phases.
		for (int p = 0; p < 5; p++) begin
			write_squaring(p[0] ^ 1'b1);
			for (int k = 0; k < 100; k++) begin
				send_sample(pick_stick(), pick_stick(), (k % 40 < 10) ? 0 : $urandom_range(0, 12));
				if (k == 50) begin
					stop_input();
					wait (sb.pending.size() == 0);
					@(negedge clk);
				end
			end
		end

		stop_input();
		wait (sb.pending.size() == 0);
		repeat (100) @(posedge clk);
		if (sb.mismatches == 0)
			$display("arcade_dead_reckoning_integrator_tb: done, clean");
		else
			$display("arcade_dead_reckoning_integrator_tb: done, errors");
		$finish;
	end
endmodule
